// ===== src/ir_keypad_number_entry_display_unit_defines.svh =====
// Assertion macros used by the checker of the keypad entry unit.
// The enclosing scope must provide clk and arst_n.
`ifndef IR_KEYPAD_NUMBER_ENTRY_DISPLAY_UNIT_DEFINES_SVH
`define IR_KEYPAD_NUMBER_ENTRY_DISPLAY_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define IRKP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IRKP_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/irkp_pkg.sv =====
`timescale 1ns / 1ps

package irkp_pkg;

	localparam int CodeW  = 16;
	localparam int LimitW = 13;
	localparam int CfgIdxW = 3;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_FIRST_DIGIT = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ZERO_DIGIT  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ENTER       = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DELETE      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OFF         = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_STOP        = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_LIMIT       = 3'd6;

	localparam logic [CodeW-1:0]  FIRST_DIGIT_RST = 16'd0;
	localparam logic [CodeW-1:0]  ZERO_DIGIT_RST  = 16'd9;
	localparam logic [CodeW-1:0]  ENTER_RST       = 16'd10;
	localparam logic [CodeW-1:0]  DELETE_RST      = 16'd11;
	localparam logic [CodeW-1:0]  OFF_RST         = 16'd12;
	localparam logic [CodeW-1:0]  STOP_RST        = 16'd13;
	localparam logic [LimitW-1:0] LIMIT_RST       = 13'd256;

	// ceil(2^19 / 10): (x * DIV10_MAGIC) >> 19 == x / 10 for any 16-bit x
	localparam logic [15:0] DIV10_MAGIC = 16'hCCCD;
	localparam int          DIV10_SHIFT = 19;

	typedef struct packed {
		logic [15:0] command_code;
		logic        is_repeat;
	} irkp_in_t;

	typedef struct packed {
		logic [15:0] entry_value;
		logic [11:0] shown_high;
		logic [3:0]  shown_low;
		logic [7:0]  high_segments;
		logic [7:0]  low_segments;
		logic        high_valid;
		logic        power_off;
	} irkp_out_t;

	typedef struct packed {
		logic [CodeW-1:0]  first_digit_code;
		logic [CodeW-1:0]  zero_digit_code;
		logic [CodeW-1:0]  enter_code;
		logic [CodeW-1:0]  delete_code;
		logic [CodeW-1:0]  off_code;
		logic [CodeW-1:0]  stop_code;
		logic [LimitW-1:0] entry_limit;
	} irkp_cfg_t;

	// hex digit to seven-segment pattern, bit i drives segment line i
	function automatic logic [7:0] seg_pattern(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'h0: p = 8'h7E;
			4'h1: p = 8'h30;
			4'h2: p = 8'h6D;
			4'h3: p = 8'h79;
			4'h4: p = 8'h33;
			4'h5: p = 8'h5B;
			4'h6: p = 8'h5F;
			4'h7: p = 8'h70;
			4'h8: p = 8'h7F;
			4'h9: p = 8'h7B;
			4'hA: p = 8'h77;
			4'hB: p = 8'h1F;
			4'hC: p = 8'h4E;
			4'hD: p = 8'h3D;
			4'hE: p = 8'h4F;
			4'hF: p = 8'h47;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

// ===== src/ir_keypad_number_entry_display_unit.sv =====
`timescale 1ns / 1ps

// Remote-control number entry with a two-digit hex display.
// Input channel (in_valid/in_ready/in_data) takes one decoded command item;
// every accepted item yields exactly one result item on the output channel
// (out_valid/out_ready/out_data): the entry after the command, the stored
// value split into hex digits with segment patterns, and a power-off pulse.
// An accepted item is registered in the input stage, processed there by
// the combinational calculator, and its result is registered in out_q.
// Throughput: one item per cycle while out_ready is high; the entry state is
// read and updated as each item advances, so items chain without bubbles.
// When the receiver stalls, the result register holds and the input stage
// fills; in_ready drops only with both stages occupied and out_ready low.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and
// must be written only while no item is in flight.
// Reset clears both stages, zeroes the entry and stored value, and loads
// the default key codes and entry limit.
module ir_keypad_number_entry_display_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  irkp_pkg::irkp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output irkp_pkg::irkp_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import irkp_pkg::*;

	irkp_cfg_t   cfg_q;
	logic [15:0] acc_q;
	logic [15:0] stored_q;
	irkp_in_t    item_s1;
	logic        valid_s1;
	irkp_out_t   out_q;
	logic        out_valid_q;

	logic        advance;
	logic [15:0] acc_next;
	logic [15:0] stored_next;
	irkp_out_t   result;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	irkp_calc u_calc (
		.cfg         (cfg_q),
		.item        (item_s1),
		.acc         (acc_q),
		.stored      (stored_q),
		.acc_next    (acc_next),
		.stored_next (stored_next),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_digit_code <= FIRST_DIGIT_RST;
			cfg_q.zero_digit_code  <= ZERO_DIGIT_RST;
			cfg_q.enter_code       <= ENTER_RST;
			cfg_q.delete_code      <= DELETE_RST;
			cfg_q.off_code         <= OFF_RST;
			cfg_q.stop_code        <= STOP_RST;
			cfg_q.entry_limit      <= LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST_DIGIT: cfg_q.first_digit_code <= cfg_data;
				REG_ZERO_DIGIT:  cfg_q.zero_digit_code  <= cfg_data;
				REG_ENTER:       cfg_q.enter_code       <= cfg_data;
				REG_DELETE:      cfg_q.delete_code      <= cfg_data;
				REG_OFF:         cfg_q.off_code         <= cfg_data;
				REG_STOP:        cfg_q.stop_code        <= cfg_data;
				REG_LIMIT:       cfg_q.entry_limit      <= cfg_data[LimitW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			stored_q    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				acc_q       <= acc_next;
				stored_q    <= stored_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q <= result;
		end
	end

endmodule

// ===== src/irkp_calc.sv =====
`timescale 1ns / 1ps

module irkp_calc (
	input  irkp_pkg::irkp_cfg_t cfg,
	input  irkp_pkg::irkp_in_t  item,
	input  logic [15:0]         acc,
	input  logic [15:0]         stored,
	output logic [15:0]         acc_next,
	output logic [15:0]         stored_next,
	output irkp_pkg::irkp_out_t result
);
	import irkp_pkg::*;

	logic        is_digit;
	logic        below_limit;
	logic [15:0] times_ten;
	logic [15:0] digit;
	logic [15:0] digit_sum;
	logic [31:0] div_prod;
	logic [15:0] tenth;
	logic        pwr;

	assign is_digit    = (item.command_code >= cfg.first_digit_code) &&
	                     (item.command_code <= cfg.zero_digit_code);
	assign below_limit = acc < {3'b000, cfg.entry_limit};

	// acc * 10 = acc * 8 + acc * 2, wrapping at 16 bits
	assign times_ten = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
	assign digit     = item.command_code - cfg.first_digit_code + 16'd1;
	assign digit_sum = times_ten +
	                   ((item.command_code == cfg.zero_digit_code) ? 16'd0 : digit);

	assign div_prod = acc * DIV10_MAGIC;
	assign tenth    = {3'b000, div_prod[31:DIV10_SHIFT]};

	always_comb begin
		acc_next    = acc;
		stored_next = stored;
		pwr         = 1'b0;
		if (!item.is_repeat) begin
			if (is_digit) begin
				if (below_limit) begin
					acc_next = digit_sum;
				end
			end else if (item.command_code == cfg.enter_code) begin
				if (below_limit) begin
					stored_next = acc;
				end
				acc_next = '0;
			end else if (item.command_code == cfg.delete_code) begin
				acc_next = tenth;
			end else if (item.command_code == cfg.off_code) begin
				pwr = 1'b1;
			end else if (item.command_code == cfg.stop_code) begin
				acc_next = '0;
			end
		end
	end

	always_comb begin
		result.entry_value   = acc_next;
		result.shown_high    = stored_next[15:4];
		result.shown_low     = stored_next[3:0];
		result.high_valid    = (stored_next[15:8] == 8'd0);
		result.high_segments = result.high_valid ? seg_pattern(stored_next[7:4]) : 8'h00;
		result.low_segments  = seg_pattern(stored_next[3:0]);
		result.power_off     = pwr;
	end

endmodule

// ===== src/irkp_checker.sv =====
`timescale 1ns / 1ps
`include "ir_keypad_number_entry_display_unit_defines.svh"

module irkp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input irkp_pkg::irkp_in_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input irkp_pkg::irkp_out_t out_data
);

	`IRKP_CHECK(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "input item changed while waiting")
	`IRKP_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result item changed while stalled")
	`IRKP_CHECK(a_ready_when_empty, !out_valid |-> in_ready, "input refused with empty output")
	`IRKP_CHECK(a_high_valid, out_valid |-> (out_data.high_valid == (out_data.shown_high <= 12'd15)), "high_valid disagrees with shown_high")
	`IRKP_CHECK_ALWAYS(a_blank_high, out_valid && !out_data.high_valid |-> out_data.high_segments == 8'h00, "invalid high digit not blanked")

endmodule

bind ir_keypad_number_entry_display_unit irkp_checker u_irkp_checker (.*);

// ===== test/ir_keypad_number_entry_display_unit_test.sv =====
`timescale 1ns / 1ps

module ir_keypad_number_entry_display_unit_test;

	import irkp_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 80;

	// seven-segment glyphs, digit 15 in the top byte
	localparam logic [16*8-1:0] SEG_GLYPHS = {
		8'h47, 8'h4F, 8'h3D, 8'h4E, 8'h1F, 8'h77, 8'h7B, 8'h7F,
		8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	irkp_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	irkp_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// mirror of the block's key map and entry state
	irkp_cfg_t   keymap = '{
		first_digit_code: FIRST_DIGIT_RST,
		zero_digit_code:  ZERO_DIGIT_RST,
		enter_code:       ENTER_RST,
		delete_code:      DELETE_RST,
		off_code:         OFF_RST,
		stop_code:        STOP_RST,
		entry_limit:      LIMIT_RST
	};
	logic [15:0] entry_acc = '0;
	logic [15:0] stored_val = '0;

	irkp_out_t   expected_readouts[$];
	int          fail_count = 0;
	int          quiet_cycles = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          hold_go = 1'b0;

	ir_keypad_number_entry_display_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic irkp_out_t apply_command(irkp_in_t c);
		irkp_out_t   r;
		logic [31:0] acc;
		logic        pwr;
		logic [11:0] hi;
		pwr = 1'b0;
		if (!c.is_repeat) begin
			if (c.command_code >= keymap.first_digit_code &&
			    c.command_code <= keymap.zero_digit_code) begin
				if (entry_acc < keymap.entry_limit) begin
					acc = 32'(entry_acc) * 32'd10;
					// digit range may be wider than ten keys
					if (c.command_code != keymap.zero_digit_code)
						acc = acc + 32'(c.command_code) - 32'(keymap.first_digit_code) + 32'd1;
					entry_acc = acc[15:0];
				end
			end else if (c.command_code == keymap.enter_code) begin
				if (entry_acc < keymap.entry_limit)
					stored_val = entry_acc;
				entry_acc = '0;
			end else if (c.command_code == keymap.delete_code) begin
				entry_acc = entry_acc / 16'd10;
			end else if (c.command_code == keymap.off_code) begin
				pwr = 1'b1;
			end else if (c.command_code == keymap.stop_code) begin
				entry_acc = '0;
			end
		end
		hi = stored_val[15:4];
		r.entry_value   = entry_acc;
		r.shown_high    = hi;
		r.shown_low     = stored_val[3:0];
		r.high_valid    = (hi <= 12'd15);
		r.high_segments = r.high_valid ? SEG_GLYPHS[hi[3:0]*8 +: 8] : 8'h00;
		r.low_segments  = SEG_GLYPHS[stored_val[3:0]*8 +: 8];
		r.power_off     = pwr;
		return r;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function automatic irkp_in_t keypress(logic [15:0] code, logic rpt = 1'b0);
		irkp_in_t c;
		c.command_code = code;
		c.is_repeat    = rpt;
		return c;
	endfunction

	function automatic irkp_in_t pick_command();
		irkp_in_t    c;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		c.command_code = 16'($urandom);
		if (roll < 55) begin
			if (keymap.first_digit_code <= keymap.zero_digit_code)
				c.command_code = keymap.first_digit_code + 16'($urandom_range(0,
					keymap.zero_digit_code - keymap.first_digit_code));
		end else if (roll < 72) begin
			c.command_code = keymap.enter_code;
		end else if (roll < 80) begin
			c.command_code = keymap.delete_code;
		end else if (roll < 85) begin
			c.command_code = keymap.stop_code;
		end else if (roll < 89) begin
			c.command_code = keymap.off_code;
		end
		c.is_repeat = ($urandom_range(0, 9) == 0);
		return c;
	endfunction

	function automatic irkp_cfg_t random_keymap();
		irkp_cfg_t   km;
		logic [15:0] base;
		base = 16'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				// arbitrary bounds: empty or very wide digit range
				km.first_digit_code = 16'($urandom);
				km.zero_digit_code  = 16'($urandom);
			end
			1: begin
				km.first_digit_code = base;
				km.zero_digit_code  = base + 16'($urandom_range(0, 15));
			end
			default: begin
				km.first_digit_code = base;
				km.zero_digit_code  = base + 16'd9;
			end
		endcase
		km.enter_code  = km.zero_digit_code + 16'd1;
		km.delete_code = km.zero_digit_code + 16'd2;
		km.off_code    = km.zero_digit_code + 16'd3;
		km.stop_code   = km.zero_digit_code + 16'd4;
		if ($urandom_range(0, 4) == 0)
			km.stop_code = 16'($urandom);
		case ($urandom_range(0, 6))
			0: km.entry_limit = 13'd0;
			1: km.entry_limit = 13'd1;
			2: km.entry_limit = 13'd6553;
			3: km.entry_limit = 13'h1FFF;
			4: km.entry_limit = 13'd256;
			default: km.entry_limit = 13'($urandom_range(1, 6553));
		endcase
		return km;
	endfunction

	// sender: one item, valid left high after acceptance
	task automatic send_command(irkp_in_t c);
		if (!tx_quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_readouts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FIRST_DIGIT: keymap.first_digit_code = data;
			REG_ZERO_DIGIT:  keymap.zero_digit_code  = data;
			REG_ENTER:       keymap.enter_code       = data;
			REG_DELETE:      keymap.delete_code      = data;
			REG_OFF:         keymap.off_code         = data;
			REG_STOP:        keymap.stop_code        = data;
			REG_LIMIT:       keymap.entry_limit      = data[LimitW-1:0];
			default: ;
		endcase
	endtask

	task automatic load_keymap(irkp_cfg_t km);
		write_reg(REG_FIRST_DIGIT, km.first_digit_code);
		write_reg(REG_ZERO_DIGIT, km.zero_digit_code);
		write_reg(REG_ENTER, km.enter_code);
		write_reg(REG_DELETE, km.delete_code);
		write_reg(REG_OFF, km.off_code);
		write_reg(REG_STOP, km.stop_code);
		// upper bits of the limit write are don't-care
		write_reg(REG_LIMIT, {3'($urandom), km.entry_limit});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_default_keys();
		send_command(keypress(16'd1));
		send_command(keypress(16'd4));
		send_command(keypress(16'd9));
		send_command(keypress(16'd0));
		send_command(keypress(16'd8));
		send_command(keypress(16'd10));		// entry over limit, not stored
		send_command(keypress(16'd1));
		send_command(keypress(16'd4));
		send_command(keypress(16'd4));
		send_command(keypress(16'd8));
		send_command(keypress(16'd11));
		send_command(keypress(16'd10, 1'b1));
		send_command(keypress(16'd10));		// stores 0xFF
		send_command(keypress(16'd12));
		send_command(keypress(16'd12, 1'b1));
		send_command(keypress(16'd6));
		send_command(keypress(16'd13));
		send_command(keypress(16'hFFFF));
	endtask

	task automatic test_wide_digit_range();
		wait_idle();
		load_keymap('{first_digit_code: 16'hFFF0, zero_digit_code: 16'hFFFF,
			enter_code: 16'h0000, delete_code: 16'h0001, off_code: 16'h0002,
			stop_code: 16'h0003, entry_limit: 13'h1FFF});
		send_command(keypress(16'hFFFA));
		send_command(keypress(16'hFFF5));
		send_command(keypress(16'hFFF1));
		send_command(keypress(16'h0000));	// stored value above 255
		send_command(keypress(16'hFFF6));
		send_command(keypress(16'hFFFF));
		send_command(keypress(16'hFFFF));
		send_command(keypress(16'hFFFF));
		send_command(keypress(16'hFFFF));	// entry wraps
		send_command(keypress(16'h0001));
		send_command(keypress(16'h0003));
	endtask

	task automatic test_overlap_and_zero_limit();
		wait_idle();
		load_keymap('{first_digit_code: 16'h8000, zero_digit_code: 16'h8005,
			enter_code: 16'h8003, delete_code: 16'hFFFF, off_code: 16'h0000,
			stop_code: 16'h0000, entry_limit: 13'd0});
		send_command(keypress(16'h8001));
		send_command(keypress(16'h8003));
		send_command(keypress(16'hFFFF));
		send_command(keypress(16'h0000));
	endtask

	task automatic test_empty_digit_range();
		wait_idle();
		load_keymap('{first_digit_code: 16'h0001, zero_digit_code: 16'h0000,
			enter_code: 16'h0001, delete_code: 16'h0000, off_code: 16'hFFFF,
			stop_code: 16'hFFFF, entry_limit: 13'd1});
		send_command(keypress(16'h0001));
		send_command(keypress(16'h0000));
		send_command(keypress(16'hFFFF));
	endtask

	task automatic test_backpressure();
		wait_idle();
		load_keymap(random_keymap());
		tx_quiet = 1'b1;
		hold_go  = 1'b1;
		repeat (20) send_command(pick_command());
		tx_quiet = 1'b0;
	endtask

	task automatic test_random_keymaps();
		repeat (8) begin
			wait_idle();
			load_keymap(random_keymap());
			repeat (45) send_command(pick_command());
		end
	endtask

	task automatic test_steady_stream();
		wait_idle();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		load_keymap(random_keymap());
		repeat (40) send_command(pick_command());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_keys();
		test_wide_digit_range();
		test_overlap_and_zero_limit();
		test_empty_digit_range();
		test_backpressure();
		test_random_keymaps();
		test_steady_stream();
		wait_idle();
		if (fail_count == 0 && expected_readouts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver: random stall bursts, one long hold when asked
	initial begin : rx_side
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			expected_readouts.push_back(apply_command(in_data));

	always @(posedge clk) begin : readout_check
		irkp_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readouts.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected readout item: %h", out_data);
			end else begin
				want = expected_readouts.pop_front();
				compare_field("entry_value", want.entry_value, out_data.entry_value);
				compare_field("shown_high", want.shown_high, out_data.shown_high);
				compare_field("shown_low", want.shown_low, out_data.shown_low);
				compare_field("high_segments", want.high_segments, out_data.high_segments);
				compare_field("low_segments", want.low_segments, out_data.low_segments);
				compare_field("high_valid", want.high_valid, out_data.high_valid);
				compare_field("power_off", want.power_off, out_data.power_off);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
